>>> rtl/core/laq_pkg.sv
// Shared definitions for the linear array queue: op and status codes,
// field widths, default depth and the controller-to-datapath command bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package laq_pkg;

  localparam int unsigned DEPTH_DEF = 128;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 8;

  localparam logic [OP_W-1:0] OP_ENQ        = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQ        = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic exec;      // input transaction taken this cycle
    logic load_out;  // move the finished result into the output register
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/laq_datapath.sv
// Datapath of the linear array queue: entry memory, head/tail pointers,
// result register and output register. Driven by laq_ctrl through laq_pkg::cmd_t.
// Depends on laq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module laq_datapath #(
  parameter int unsigned DEPTH = laq_pkg::DEPTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire laq_pkg::cmd_t                         cmd_i,
  input  wire logic        [laq_pkg::OP_W-1:0]       op_i,
  input  wire logic signed [laq_pkg::DATA_W-1:0]     push_value_i,
  output logic signed      [laq_pkg::DATA_W-1:0]     read_value_o,
  output logic             [laq_pkg::STATUS_W-1:0]   status_o,
  output logic             [laq_pkg::OCC_W-1:0]      occupancy_o,
  output logic                                       is_empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = (AW + 1 > laq_pkg::OCC_W) ? AW + 1 : laq_pkg::OCC_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic signed [laq_pkg::DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic          empty_q, empty_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic [laq_pkg::STATUS_W-1:0] st;

  logic [AW:0]   occ_full;
  logic [OW-1:0] occ_ext;

  // result of the last executed transaction
  logic signed [laq_pkg::DATA_W-1:0] rd_q;
  logic                              rd_hit_q;
  logic [laq_pkg::STATUS_W-1:0]      res_st_q;
  logic [laq_pkg::OCC_W-1:0]         res_occ_q;
  logic                              res_empty_q;

  // output register
  logic signed [laq_pkg::DATA_W-1:0] out_val_q;
  logic [laq_pkg::STATUS_W-1:0]      out_st_q;
  logic [laq_pkg::OCC_W-1:0]         out_occ_q;
  logic                              out_empty_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    we      = 1'b0;
    waddr   = tail_q;
    rd_en   = 1'b0;
    raddr   = head_q;
    st      = laq_pkg::ST_OK;
    case (op_i)
      laq_pkg::OP_ENQ: begin
        if (empty_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b0;
          we      = 1'b1;
          waddr   = '0;
        end else if (tail_q == LAST) begin
          st = laq_pkg::ST_FULL;
        end else begin
          tail_d = tail_q + AW'(1);
          we     = 1'b1;
          waddr  = tail_q + AW'(1);
        end
      end
      laq_pkg::OP_DEQ: begin
        if (empty_q) begin
          st = laq_pkg::ST_EMPTY;
        end else begin
          rd_en = 1'b1;
          raddr = head_q;
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            head_d = head_q + AW'(1);
          end
        end
      end
      laq_pkg::OP_PEEK_FRONT: begin
        if (empty_q) begin
          st = laq_pkg::ST_EMPTY;
        end else begin
          rd_en = 1'b1;
          raddr = head_q;
        end
      end
      laq_pkg::OP_PEEK_REAR: begin
        if (empty_q) begin
          st = laq_pkg::ST_EMPTY;
        end else begin
          rd_en = 1'b1;
          raddr = tail_q;
        end
      end
      laq_pkg::OP_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign occ_full = empty_d ? '0 : ({1'b0, tail_d} - {1'b0, head_d} + (AW+1)'(1));
  assign occ_ext  = OW'(occ_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[waddr] <= push_value_i;
    end
    if (cmd_i.exec && rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_hit_q    <= rd_en;
      res_st_q    <= st;
      res_occ_q   <= occ_ext[laq_pkg::OCC_W-1:0];
      res_empty_q <= empty_d;
    end
    if (cmd_i.load_out) begin
      out_val_q   <= rd_hit_q ? rd_q : '0;
      out_st_q    <= res_st_q;
      out_occ_q   <= res_occ_q;
      out_empty_q <= res_empty_q;
    end
  end

  assign read_value_o = out_val_q;
  assign status_o     = out_st_q;
  assign occupancy_o  = out_occ_q;
  assign is_empty_o   = out_empty_q;

endmodule

`default_nettype wire

>>> rtl/core/laq_ctrl.sv
// Controller of the linear array queue: tracks a pending result and the
// output register's valid, issues laq_pkg::cmd_t to the datapath.
// Depends on laq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module laq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output laq_pkg::cmd_t      cmd_o
);

  localparam logic S_IDLE = 1'b0;  // no result waiting in the datapath
  localparam logic S_PEND = 1'b1;  // result register holds an undelivered result

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    in_stall_o     = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PEND;
        end
      end
      S_PEND: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = in_valid_i ? S_PEND : S_IDLE;
        end else begin
          in_stall_o = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.exec = in_valid_i && !in_stall_o;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_stall_only_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (state_q == S_PEND))
    else $error("input stalled with no pending result");

  a_load_only_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (state_q == S_PEND))
    else $error("output load without a pending result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.load_out)
    else $error("output register overwritten while stalled");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");

  a_accept_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> (state_q == S_PEND))
    else $error("accepted transaction lost");

endmodule

`default_nettype wire

>>> rtl/core/linear_array_queue_top.sv
// Linear (non-circular) queue of signed 32-bit values with one result per
// transaction: enqueue, dequeue, peek front/rear, clear, query. The entries sit
// in a DEPTH-deep memory with one write and one registered read port; the
// queue reports full once the tail reaches the last slot, and the pointers
// return to zero only when the queue empties or is cleared. A transaction
// is executed at the edge it is accepted (memory access and pointer update)
// and its result waits in the result register until it moves to the output
// register; throughput is one transaction per cycle while the output side
// takes results; the input stalls only while a finished result cannot move
// into a stalled output register. Entry contents are not cleared at reset.
// Depends on laq_pkg, laq_ctrl, laq_datapath.
`timescale 1ns / 1ps
`default_nettype none

module linear_array_queue_top #(
  parameter int unsigned DEPTH = laq_pkg::DEPTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic        [laq_pkg::OP_W-1:0]       op_i,
  input  wire logic signed [laq_pkg::DATA_W-1:0]     push_value_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed      [laq_pkg::DATA_W-1:0]     read_value_o,
  output logic             [laq_pkg::STATUS_W-1:0]   status_o,
  output logic             [laq_pkg::OCC_W-1:0]      occupancy_o,
  output logic                                       is_empty_o
);

  laq_pkg::cmd_t cmd;

  laq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  laq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (op_i),
    .push_value_i (push_value_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o),
    .is_empty_o   (is_empty_o)
  );

endmodule

`default_nettype wire
